### hw/rtl/spc_pkg.sv
// Shared constants, widths and request structs for the sphere pair collision time block.
package spc_pkg;

    // Coordinate format: signed Q(COORD_BITS-FRAC_BITS).FRAC_BITS
    localparam int COORD_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int RAD_W       = COORD_BITS - 1;
    localparam int PROD_W      = 2 * COORD_BITS;
    localparam int DOT_W       = PROD_W + 2;
    localparam int DVAL_W      = 4 * COORD_BITS;
    localparam int ROOT_W      = PROD_W + FRAC_BITS;
    localparam int REM_W       = ROOT_W + 2;
    localparam int DIV_W       = 3 * COORD_BITS + FRAC_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request as it leaves the front end
    typedef struct packed {
        logic              miss;
        logic [PROD_W-1:0] dot;
        logic [PROD_W-1:0] vv;
        logic [DVAL_W-1:0] dval;
    } spc_item_t;

    // What the back end carries alongside the root
    typedef struct packed {
        logic              miss;
        logic [PROD_W-1:0] dot;
        logic [PROD_W-1:0] vv;
    } spc_work_t;

endpackage

### hw/rtl/spc_front.sv
// Front end: accepts a request, forms dot products and the discriminant, flags misses.
module spc_front
    import spc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         q_full,
    input  logic signed [COORD_BITS-1:0] rel_pos_x,
    input  logic signed [COORD_BITS-1:0] rel_pos_y,
    input  logic signed [COORD_BITS-1:0] rel_pos_z,
    input  logic signed [COORD_BITS-1:0] rel_vel_x,
    input  logic signed [COORD_BITS-1:0] rel_vel_y,
    input  logic signed [COORD_BITS-1:0] rel_vel_z,
    input  logic        [RAD_W-1:0]      radius_first,
    input  logic        [RAD_W-1:0]      radius_second,
    output logic                         push,
    output spc_item_t                    item
);

    localparam int H = COORD_BITS;

    logic adv;
    logic v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_e_reg, v_f_reg;

    logic signed [COORD_BITS-1:0] pos [3];
    logic signed [COORD_BITS-1:0] vel [3];

    // stage A
    logic signed [PROD_W-1:0] dot_p_reg [3];
    logic signed [PROD_W-1:0] vv_p_reg  [3];
    logic signed [PROD_W-1:0] pp_p_reg  [3];
    logic [COORD_BITS-1:0]    rsum_reg;
    // stage B
    logic signed [DOT_W-1:0]  dot_reg;
    logic [PROD_W-1:0]        vv_b_reg, pp_reg, rr_reg;
    // stage C
    logic [PROD_W:0]          e_diff;
    logic                     e_neg_c_reg, miss_c_reg;
    logic [PROD_W-1:0]        e_mag_reg, dmag_c_reg, vv_c_reg;
    // stage D
    logic [PROD_W-1:0]        ve_ll_reg, ve_lh_reg, ve_hl_reg, ve_hh_reg;
    logic [PROD_W-1:0]        dd_ll_reg, dd_lh_reg, dd_hh_reg;
    logic                     e_neg_d_reg, miss_d_reg;
    logic [PROD_W-1:0]        dmag_d_reg, vv_d_reg;
    // stage E
    logic [DVAL_W-1:0]        p1_reg, q_reg;
    logic                     e_neg_e_reg, miss_e_reg;
    logic [PROD_W-1:0]        dmag_e_reg, vv_e_reg;
    // stage F
    spc_item_t                item_reg;

    assign pos[0] = rel_pos_x;
    assign pos[1] = rel_pos_y;
    assign pos[2] = rel_pos_z;
    assign vel[0] = rel_vel_x;
    assign vel[1] = rel_vel_y;
    assign vel[2] = rel_vel_z;

    // whole front stalls only when its last stage cannot enter the queue
    assign adv  = !(v_f_reg && q_full);
    assign push = v_f_reg && !q_full;
    assign item = item_reg;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
            v_e_reg <= 1'b0;
            v_f_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_a_reg <= accept;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
            v_d_reg <= v_c_reg;
            v_e_reg <= v_d_reg;
            v_f_reg <= v_e_reg;
        end
    end

    // stage A: nine products and the radius sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dot_p_reg[i] <= vel[i] * pos[i];
                vv_p_reg[i]  <= vel[i] * vel[i];
                pp_p_reg[i]  <= pos[i] * pos[i];
            end
            rsum_reg <= {1'b0, radius_first} + {1'b0, radius_second};
        end
    end

    // stage B: sums and squared radius sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dot_reg  <= dot_p_reg[0] + dot_p_reg[1] + dot_p_reg[2];
            vv_b_reg <= $unsigned(vv_p_reg[0]) + $unsigned(vv_p_reg[1])
                        + $unsigned(vv_p_reg[2]);
            pp_reg   <= $unsigned(pp_p_reg[0]) + $unsigned(pp_p_reg[1])
                        + $unsigned(pp_p_reg[2]);
            rr_reg   <= rsum_reg * rsum_reg;
        end
    end

    // stage C: e = R^2 - |p|^2 as sign and magnitude, moving-apart test
    assign e_diff = {1'b0, rr_reg} - {1'b0, pp_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_neg_c_reg <= e_diff[PROD_W];
            e_mag_reg   <= e_diff[PROD_W] ? PROD_W'(-e_diff) : e_diff[PROD_W-1:0];
            miss_c_reg  <= dot_reg[DOT_W-1] || (dot_reg == '0);
            dmag_c_reg  <= dot_reg[PROD_W-1:0];
            vv_c_reg    <= vv_b_reg;
        end
    end

    // stage D: half-width partial products of vv*|e| and dot^2
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ve_ll_reg   <= vv_c_reg[H-1:0]      * e_mag_reg[H-1:0];
            ve_lh_reg   <= vv_c_reg[H-1:0]      * e_mag_reg[PROD_W-1:H];
            ve_hl_reg   <= vv_c_reg[PROD_W-1:H] * e_mag_reg[H-1:0];
            ve_hh_reg   <= vv_c_reg[PROD_W-1:H] * e_mag_reg[PROD_W-1:H];
            dd_ll_reg   <= dmag_c_reg[H-1:0]      * dmag_c_reg[H-1:0];
            dd_lh_reg   <= dmag_c_reg[H-1:0]      * dmag_c_reg[PROD_W-1:H];
            dd_hh_reg   <= dmag_c_reg[PROD_W-1:H] * dmag_c_reg[PROD_W-1:H];
            e_neg_d_reg <= e_neg_c_reg;
            miss_d_reg  <= miss_c_reg;
            dmag_d_reg  <= dmag_c_reg;
            vv_d_reg    <= vv_c_reg;
        end
    end

    // stage E: assemble the two wide products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= DVAL_W'(ve_ll_reg) + (DVAL_W'(ve_lh_reg) << H)
                      + (DVAL_W'(ve_hl_reg) << H) + (DVAL_W'(ve_hh_reg) << (2 * H));
            q_reg  <= DVAL_W'(dd_ll_reg) + (DVAL_W'(dd_lh_reg) << (H + 1))
                      + (DVAL_W'(dd_hh_reg) << (2 * H));
            e_neg_e_reg <= e_neg_d_reg;
            miss_e_reg  <= miss_d_reg;
            dmag_e_reg  <= dmag_d_reg;
            vv_e_reg    <= vv_d_reg;
        end
    end

    // stage F: discriminant D = dot^2 + vv*(R^2 - |p|^2), miss when negative
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg.miss <= miss_e_reg || (e_neg_e_reg && (p1_reg > q_reg));
            item_reg.dot  <= dmag_e_reg;
            item_reg.vv   <= vv_e_reg;
            item_reg.dval <= e_neg_e_reg ? (q_reg - p1_reg) : (q_reg + p1_reg);
        end
    end

endmodule

### hw/rtl/spc_queue.sv
// Short request queue between the front and back ends.
module spc_queue
    import spc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  spc_item_t wr_item,
    output logic      full,
    output logic      pop,
    output spc_item_t rd_item
);

    spc_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    // back end never stalls: drain whenever something is stored
    assign pop     = (count_reg != '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> count_reg == $past(count_reg) + QCNT_W'($past(push))
                                      - QCNT_W'($past(pop)))
        else $error("queue count lost a request");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

### hw/rtl/spc_sqrt.sv
// Back end part one: pipelined integer square root, one root bit per stage.
module spc_sqrt
    import spc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  spc_item_t         in_item,
    output logic              out_valid,
    output spc_work_t         out_work,
    output logic [ROOT_W-1:0] out_root
);

    localparam int X_W = 2 * ROOT_W;

    logic              valid_reg [1:ROOT_W];
    spc_work_t         work_reg  [1:ROOT_W];
    logic [REM_W-1:0]  rem_reg   [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg  [1:ROOT_W];
    logic [X_W-1:0]    xs_reg    [1:ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic              v_in;
            spc_work_t         w_in;
            logic [REM_W-1:0]  rem_in, r2, trial;
            logic [ROOT_W-1:0] root_in;
            logic [X_W-1:0]    xs_in;

            if (k == 0)
            begin : g_src
                assign v_in    = in_valid;
                assign w_in    = '{miss: in_item.miss, dot: in_item.dot, vv: in_item.vv};
                assign rem_in  = '0;
                assign root_in = '0;
                // radicand is D scaled by 2^(2*FRAC_BITS)
                assign xs_in   = {in_item.dval, {(2 * FRAC_BITS){1'b0}}};
            end
            else
            begin : g_chain
                assign v_in    = valid_reg[k];
                assign w_in    = work_reg[k];
                assign rem_in  = rem_reg[k];
                assign root_in = root_reg[k];
                assign xs_in   = xs_reg[k];
            end

            // bring down two radicand bits, try (root<<2)|1
            assign r2    = {rem_in[REM_W-3:0], xs_in[X_W-1 -: 2]};
            assign trial = {root_in, 2'b01};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k+1] <= 1'b0;
                end
                else
                begin
                    valid_reg[k+1] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                work_reg[k+1] <= w_in;
                xs_reg[k+1]   <= {xs_in[X_W-3:0], 2'b00};
                if (r2 >= trial)
                begin
                    rem_reg[k+1]  <= r2 - trial;
                    root_reg[k+1] <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= r2;
                    root_reg[k+1] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W];
    assign out_work  = work_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];

endmodule

### hw/rtl/spc_divide.sv
// Back end part two: numerator, pipelined restoring divide by |v|^2, rounding and clamp.
module spc_divide
    import spc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  spc_work_t                    in_work,
    input  logic        [ROOT_W-1:0]     in_root,
    output logic                         done,
    output logic                         hit,
    output logic signed [COORD_BITS-1:0] contact_time,
    output logic                         time_saturated
);

    localparam int CB = COORD_BITS;
    localparam logic [CB-1:0] T_MAX = {1'b0, {(CB - 1){1'b1}}};
    localparam logic [CB-1:0] T_MIN = {1'b1, {(CB - 1){1'b0}}};

    // numerator stage
    logic [ROOT_W-1:0] num_a;
    logic              n_valid_reg, n_neg_reg, n_miss_reg;
    logic [ROOT_W-1:0] n_mag_reg;
    logic [PROD_W-1:0] n_vv_reg;

    // divide chain
    logic              d_valid_reg [1:CB];
    logic              d_neg_reg   [1:CB];
    logic              d_miss_reg  [1:CB];
    logic              d_ovf_reg   [1:CB];
    logic [PROD_W-1:0] d_vv_reg    [1:CB];
    logic [DIV_W-1:0]  d_rem_reg   [1:CB];
    logic [CB-1:0]     d_q_reg     [1:CB];

    // result
    logic              done_reg, hit_reg, sat_reg;
    logic [CB-1:0]     time_reg;
    logic [CB:0]       q_ceil;
    logic              f_remnz;

    // numerator: dot * 2^FRAC_BITS - root, as sign and magnitude
    assign num_a = {in_work.dot, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else
        begin
            n_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        n_neg_reg  <= in_root > num_a;
        n_mag_reg  <= (in_root > num_a) ? (in_root - num_a) : (num_a - in_root);
        n_miss_reg <= in_work.miss;
        n_vv_reg   <= in_work.vv;
    end

    genvar k;
    generate
        for (k = 0; k < CB; k++)
        begin : g_step
            logic              v_in, neg_in, miss_in, ovf_in;
            logic [PROD_W-1:0] vv_in;
            logic [DIV_W-1:0]  rem_in, dsh;
            logic [CB-1:0]     q_in;

            if (k == 0)
            begin : g_src
                assign v_in    = n_valid_reg;
                assign neg_in  = n_neg_reg;
                assign miss_in = n_miss_reg;
                assign vv_in   = n_vv_reg;
                assign rem_in  = DIV_W'(n_mag_reg);
                assign q_in    = '0;
                // quotient of CB bits or more is out of range either way
                assign ovf_in  = DIV_W'(n_mag_reg) >= (DIV_W'(n_vv_reg) << CB);
            end
            else
            begin : g_chain
                assign v_in    = d_valid_reg[k];
                assign neg_in  = d_neg_reg[k];
                assign miss_in = d_miss_reg[k];
                assign vv_in   = d_vv_reg[k];
                assign rem_in  = d_rem_reg[k];
                assign q_in    = d_q_reg[k];
                assign ovf_in  = d_ovf_reg[k];
            end

            assign dsh = DIV_W'(vv_in) << (CB - 1 - k);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    d_valid_reg[k+1] <= 1'b0;
                end
                else
                begin
                    d_valid_reg[k+1] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                d_neg_reg[k+1]  <= neg_in;
                d_miss_reg[k+1] <= miss_in;
                d_ovf_reg[k+1]  <= ovf_in;
                d_vv_reg[k+1]   <= vv_in;
                if (!ovf_in && (rem_in >= dsh))
                begin
                    d_rem_reg[k+1] <= rem_in - dsh;
                    d_q_reg[k+1]   <= {q_in[CB-2:0], 1'b1};
                end
                else
                begin
                    d_rem_reg[k+1] <= rem_in;
                    d_q_reg[k+1]   <= {q_in[CB-2:0], 1'b0};
                end
            end
        end
    endgenerate

    // negative times round toward minus infinity: ceil of the magnitude
    assign f_remnz = (d_rem_reg[CB] != '0);
    assign q_ceil  = {1'b0, d_q_reg[CB]} + (CB + 1)'(f_remnz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid_reg[CB];
        end
    end

    // final select and clamp
    always_ff @(posedge clk)
    begin
        if (d_miss_reg[CB])
        begin
            hit_reg  <= 1'b0;
            time_reg <= T_MAX;
            sat_reg  <= 1'b0;
        end
        else if (!d_neg_reg[CB])
        begin
            hit_reg <= 1'b1;
            if (d_ovf_reg[CB] || d_q_reg[CB][CB-1])
            begin
                time_reg <= T_MAX;
                sat_reg  <= 1'b1;
            end
            else
            begin
                time_reg <= d_q_reg[CB];
                sat_reg  <= 1'b0;
            end
        end
        else
        begin
            hit_reg <= 1'b1;
            if (d_ovf_reg[CB] || (q_ceil > {1'b0, T_MIN}))
            begin
                time_reg <= T_MIN;
                sat_reg  <= 1'b1;
            end
            else
            begin
                time_reg <= CB'(-q_ceil);
                sat_reg  <= 1'b0;
            end
        end
    end

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign contact_time   = time_reg;
    assign time_saturated = sat_reg;

endmodule

### hw/rtl/sphere_pair_collision_time.sv
// Top level: moving sphere pair hit test and time to first contact.
// Path from the accepting edge to the done strobe:
//   6 front stages, queue, ROOT_W = 80 root stages, numerator, 32 divide stages, output.
// Throughput: one request per cycle; the back end never stalls, so busy stays low in use.
// Reset: rst_n clears all valid bits and the queue; no clearing pass, ready right after reset.
// Results appear for one cycle on done and cannot be held off.
module sphere_pair_collision_time
    import spc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] rel_pos_x,
    input  logic signed [COORD_BITS-1:0] rel_pos_y,
    input  logic signed [COORD_BITS-1:0] rel_pos_z,
    input  logic signed [COORD_BITS-1:0] rel_vel_x,
    input  logic signed [COORD_BITS-1:0] rel_vel_y,
    input  logic signed [COORD_BITS-1:0] rel_vel_z,
    input  logic        [RAD_W-1:0]      radius_first,
    input  logic        [RAD_W-1:0]      radius_second,
    output logic                         done,
    output logic                         hit,
    output logic signed [COORD_BITS-1:0] contact_time,
    output logic                         time_saturated
);

    logic              q_full, push, pop, accept;
    spc_item_t         f_item, q_item;
    logic              s_valid;
    spc_work_t         s_work;
    logic [ROOT_W-1:0] s_root;

    assign busy   = q_full;
    assign accept = start && !busy;

    // front end
    spc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .q_full        (q_full),
        .rel_pos_x     (rel_pos_x),
        .rel_pos_y     (rel_pos_y),
        .rel_pos_z     (rel_pos_z),
        .rel_vel_x     (rel_vel_x),
        .rel_vel_y     (rel_vel_y),
        .rel_vel_z     (rel_vel_z),
        .radius_first  (radius_first),
        .radius_second (radius_second),
        .push          (push),
        .item          (f_item)
    );

    // decoupling queue
    spc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (f_item),
        .full    (q_full),
        .pop     (pop),
        .rd_item (q_item)
    );

    // back end: root then divide
    spc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop),
        .in_item   (q_item),
        .out_valid (s_valid),
        .out_work  (s_work),
        .out_root  (s_root)
    );

    spc_divide u_divide (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_valid),
        .in_work        (s_work),
        .in_root        (s_root),
        .done           (done),
        .hit            (hit),
        .contact_time   (contact_time),
        .time_saturated (time_saturated)
    );

endmodule
